// ===== hdl/nearest_palette_color_search_top_assert.svh =====
// Assertion macros for the nearest palette color search block.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_TOP_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked only while the block is out of reset.
`define NPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define NPS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define NPS_ASSERT(lbl, prop, msg)
`define NPS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== hdl/nps_pkg.sv =====
// Shared constants and types of the nearest palette color search block.
`timescale 1ns / 1ps
package nps_pkg;

    localparam int PALETTE_ENTRIES = 64;
    localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
    localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
    localparam int IDX_W           = 6;
    localparam int COLOR_W         = 8;
    localparam int SQ_W            = 2 * COLOR_W;
    localparam int DIST_W          = SQ_W + 2;
    localparam int S_TDATA_W       = 32;
    localparam int M_TDATA_W       = 8;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    localparam int RGB_W = $bits(rgb_t);

    typedef struct packed {
        logic valid;
        rgb_t color;
    } default_cfg_t;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_QUERY,
        CMD_DEFAULT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [ADDR_W-1:0] addr;
        rgb_t              color;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

// ===== hdl/nps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module nps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/nps_front.sv =====
// Front end: takes input transfers and classifies them into commands.
`timescale 1ns / 1ps
module nps_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nps_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  nps_pkg::default_cfg_t         default_cfg,
    input  nps_pkg::queue_status_t        q_status,
    output logic                          push,
    output nps_pkg::cmd_t                 push_cmd
);
    import nps_pkg::*;

    logic [IDX_W-1:0] entry_index;
    rgb_t             color;
    logic             in_range;
    logic             default_hit;

    assign entry_index = s_tdata[IDX_W-1:0];
    assign color.red   = s_tdata[IDX_W +: COLOR_W];
    assign color.green = s_tdata[IDX_W + COLOR_W +: COLOR_W];
    assign color.blue  = s_tdata[IDX_W + 2 * COLOR_W +: COLOR_W];

    // Writes past the end of the palette are taken and dropped.
    assign in_range    = 32'(entry_index) < 32'(PALETTE_ENTRIES);
    assign default_hit = default_cfg.valid && (default_cfg.color == color);

    assign s_tready = !q_status.full;

    always_comb begin
        push_cmd.addr  = ADDR_W'(entry_index);
        push_cmd.color = color;
        if (s_tuser == OP_WRITE) begin
            push_cmd.kind = CMD_WRITE;
        end else if (default_hit) begin
            push_cmd.kind = CMD_DEFAULT;
        end else begin
            push_cmd.kind = CMD_QUERY;
        end
    end

    assign push = s_tvalid && s_tready && ((s_tuser == OP_QUERY) || in_range);

endmodule

// ===== hdl/nps_fifo.sv =====
// Short command queue between the front end and the search engine.
`timescale 1ns / 1ps
module nps_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  nps_pkg::cmd_t          push_cmd,
    input  logic                   pop,
    output nps_pkg::cmd_t          head_cmd,
    output nps_pkg::queue_status_t q_status
);
    import nps_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd       = entry_reg[rd_ptr_reg];
    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

endmodule

// ===== hdl/nps_back.sv =====
// Back end: executes palette writes and runs the nearest color scan.
`timescale 1ns / 1ps
module nps_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  nps_pkg::cmd_t          head_cmd,
    input  nps_pkg::queue_status_t q_status,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [nps_pkg::IDX_W-1:0] m_match_index,
    output logic                   m_is_default
);
    import nps_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    rgb_t               query_reg, query_next;
    logic [DIST_W-1:0]  best_dist_reg, best_dist_next;
    logic [ADDR_W-1:0]  best_idx_reg, best_idx_next;
    logic               v1_reg, v1_next;
    logic               v2_reg, v2_next;
    logic               m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]   m_index_reg, m_index_next;
    logic               m_default_reg, m_default_next;

    // Datapath pipeline, no reset needed.
    logic [ADDR_W-1:0]  idx1_reg, idx2_reg;
    logic               last1_reg, last2_reg;
    logic [SQ_W-1:0]    sq_r_reg, sq_g_reg, sq_b_reg;

    logic               out_free;
    logic               issue;
    logic               ram_we;
    logic [RGB_W-1:0]   ram_rd_data;
    rgb_t               entry;
    logic [DIST_W-1:0]  cand_dist;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                                input logic [COLOR_W-1:0] b);
        logic [COLOR_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    nps_ram #(
        .WIDTH(RGB_W),
        .DEPTH(PALETTE_ENTRIES)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (head_cmd.addr),
        .wr_data (head_cmd.color),
        .rd_addr (cnt_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign entry    = rgb_t'(ram_rd_data);
    assign out_free = !m_valid_reg || m_ready;
    assign issue    = (state_reg == ST_SCAN) && (cnt_reg != CNT_W'(PALETTE_ENTRIES));
    assign ram_we   = (state_reg == ST_IDLE) && !q_status.empty && (head_cmd.kind == CMD_WRITE);
    assign pop      = (state_reg == ST_IDLE) && !q_status.empty &&
                      ((head_cmd.kind != CMD_DEFAULT) || out_free);
    assign cand_dist = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        query_next     = query_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        v1_next        = issue;
        v2_next        = v1_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_index_next   = m_index_reg;
        m_default_next = m_default_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    case (head_cmd.kind)
                        CMD_QUERY: begin
                            query_next     = head_cmd.color;
                            cnt_next       = '0;
                            best_dist_next = '1;
                            best_idx_next  = '0;
                            state_next     = ST_SCAN;
                        end
                        CMD_DEFAULT: begin
                            if (out_free) begin
                                m_valid_next   = 1'b1;
                                m_index_next   = '0;
                                m_default_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                // Strict compare keeps the lowest index on ties.
                if (v2_reg && (cand_dist < best_dist_reg)) begin
                    best_dist_next = cand_dist;
                    best_idx_next  = idx2_reg;
                end
                if (v2_reg && last2_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_index_next   = IDX_W'(best_idx_reg);
                    m_default_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_default_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            m_valid_reg   <= m_valid_next;
            m_default_reg <= m_default_next;
        end
        query_reg     <= query_next;
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        m_index_reg   <= m_index_next;
    end

    always_ff @(posedge aclk) begin
        idx1_reg  <= cnt_reg[ADDR_W-1:0];
        last1_reg <= (cnt_reg == CNT_W'(PALETTE_ENTRIES - 1));
        idx2_reg  <= idx1_reg;
        last2_reg <= last1_reg;
        sq_r_reg  <= sq_diff(entry.red, query_reg.red);
        sq_g_reg  <= sq_diff(entry.green, query_reg.green);
        sq_b_reg  <= sq_diff(entry.blue, query_reg.blue);
    end

    assign m_valid       = m_valid_reg;
    assign m_match_index = m_index_reg;
    assign m_is_default  = m_default_reg;

endmodule

// ===== hdl/nearest_palette_color_search_top.sv =====
// Top level of the nearest palette color search block.
// A query scans every palette entry, one entry per cycle through the single read port of the palette
// RAM, before its result is offered; the next query starts its scan only after this one has finished.
// Writes and default hits need no scan.
// Reset: aresetn is synchronous and active low; it clears control state and the default
// color registers. Palette contents are not cleared and must be written before any query.
`timescale 1ns / 1ps
`include "nearest_palette_color_search_top_assert.svh"
module nearest_palette_color_search_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata from bit 0: entry_index[5:0], red[13:6], green[21:14], blue[29:22], zero pad.
    input  logic [nps_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: op (0 writes a palette entry, 1 queries the nearest color).
    input  logic [0:0]                      s_tuser,
    // Result channel.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata from bit 0: match_index[5:0], zero pad.
    output logic [nps_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: is_default.
    output logic [0:0]                      m_tuser,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nps_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import nps_pkg::*;

    // Register map of the configuration channel.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEFAULT_VALID,
        REG_DEFAULT_RED,
        REG_DEFAULT_GREEN,
        REG_DEFAULT_BLUE
    } cfg_reg_t;

    default_cfg_t  cfg_reg, cfg_next;
    cmd_t          push_cmd;
    cmd_t          head_cmd;
    queue_status_t q_status;
    logic          push;
    logic          pop;
    logic [IDX_W-1:0] match_index;
    logic          is_default;

    // Configuration writes are always taken. Software must write only while the block is idle; the block
    // itself does not enforce it. Then the default color seen by the front end is stable for every query it classifies.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_DEFAULT_VALID: cfg_next.valid       = cfg_data[0];
                REG_DEFAULT_RED:   cfg_next.color.red   = cfg_data[COLOR_W-1:0];
                REG_DEFAULT_GREEN: cfg_next.color.green = cfg_data[COLOR_W-1:0];
                REG_DEFAULT_BLUE:  cfg_next.color.blue  = cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end checks for the default color and sorts each transfer into a
    // palette write, a default hit or a full search, then queues it.
    nps_front u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser[0]),
        .default_cfg (cfg_reg),
        .q_status    (q_status),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // The queue lets new transfers arrive while the back end is scanning.
    nps_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_status (q_status)
    );

    // The back end performs commands strictly in order, so a write queued behind a
    // query lands only after that query has finished its scan.
    nps_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_cmd      (head_cmd),
        .q_status      (q_status),
        .pop           (pop),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_match_index (match_index),
        .m_is_default  (is_default)
    );

    assign m_tdata    = M_TDATA_W'(match_index);
    assign m_tuser[0] = is_default;

    // A default hit always reports index zero.
    `NPS_ASSERT(a_default_index_zero, m_tvalid && m_tuser[0] |-> m_tdata[IDX_W-1:0] == '0, "default result with nonzero index")
    // A default hit can only come from a configured default color.
    `NPS_ASSERT(a_default_needs_valid, m_tvalid && m_tuser[0] |-> cfg_reg.valid, "default result while no default configured")
    // The queue can never look full and empty at once.
    `NPS_ASSERT(a_queue_status, !(q_status.full && q_status.empty), "queue reports full and empty")
    // No result is offered right after reset.
    `NPS_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule
